/* rtl/core/view_cone_visibility_test_assert.svh */
// Assertion macros shared by the view-cone visibility test RTL.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef VIEW_CONE_VISIBILITY_TEST_ASSERT_SVH
`define VIEW_CONE_VISIBILITY_TEST_ASSERT_SVH

// Same-cycle implication.
`define VCT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vct_pkg.sv */
// Shared types and fixed constants of the view-cone visibility test.
// No dependencies; used by vct_mul and view_cone_visibility_test.
`timescale 1ns / 1ps

package vct_pkg;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK,
        ST_POSE,
        ST_DIST,
        ST_ZT,
        ST_DONE
    } state_t;

    localparam int DIR_W  = 17;
    localparam int OFF_W  = 25;
    localparam int MAG_W  = 24;
    localparam int DIST_W = 48;
    localparam int RSQ_W  = 46;
    localparam int Z_W    = 42;
    localparam int SQ_W   = 84;
    localparam int ACC_W  = 40;
    localparam int ANG_W  = 14;
    localparam int QTR_W  = 12;

    localparam logic [QTR_W-1:0] QUARTER_POSE = 12'd1440;
    localparam logic [QTR_W-1:0] QUARTER_CONE = 12'd2880;
    localparam int RECIP_SH = 40;
    localparam longint unsigned RECIP_POSE = (64'd1 << RECIP_SH) / 64'd1440;
    localparam longint unsigned RECIP_CONE = (64'd1 << RECIP_SH) / 64'd2880;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [1:19] = '{6, 20, 42, 72, 110, 156, 210, 272, 342,
        420, 506, 600, 702, 812, 930, 1056, 1190, 1332, 1482};

endpackage

/* rtl/core/vct_mul.sv */
// Shared signed 32x32 multiplier with a registered product.
// Depends on vct_pkg for operand and product types.
`timescale 1ns / 1ps

module vct_mul (
    input  logic              clk,
    input  vct_pkg::mul_op_t   op_a,
    input  vct_pkg::mul_op_t   op_b,
    output vct_pkg::mul_prod_t prod
);
    import vct_pkg::*;

    mul_prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/view_cone_visibility_test.sv */
// View-cone visibility test. A pose transfer (func 0) stores the viewer position and
// derives the view direction through six sine lookups and then seven multiply steps;
// it yields no result. An object transfer (func 1) yields one result: it finishes
// with no test for the owner or a far object, after the range test when that test
// fails or the cone is wider than a half turn, and otherwise after the full cone test.
// All products go through one registered 32x32 multiplier; the block takes one item
// at a time and holds in_stall high until it is done.
// A finished result waits in the output register while a new item is taken.
`timescale 1ns / 1ps

module view_cone_visibility_test #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int COORD_WIDTH      = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic [12:0]                   rot_x,
    input  logic [12:0]                   rot_y,
    input  logic [12:0]                   rot_z,
    input  logic [15:0]                   object_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   result_id,
    output logic                          visible,
    output logic                          reachable
);
    import vct_pkg::*;
    `include "view_cone_visibility_test_assert.svh"

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int N_W   = $clog2(2880 * SINE_TABLE_DEPTH + 1441);
    localparam int EXT_W = 33;

    localparam logic [1:0] REG_VISION_RANGE = 2'd0;
    localparam logic [1:0] REG_REACH_RANGE  = 2'd1;
    localparam logic [1:0] REG_VISION_ANGLE = 2'd2;
    localparam logic [1:0] REG_OWNER_ID     = 2'd3;

    localparam logic FUNC_POSE = 1'b0;

    localparam logic [2:0] LK_LAST_POSE = 3'd5;
    localparam logic [2:0] LK_CONE      = 3'd6;
    localparam logic [1:0] LK_LAST      = 2'd3;
    localparam logic [3:0] POSE_LAST    = 4'd6;
    localparam logic [3:0] DIST_LAST    = 4'd5;
    localparam logic [3:0] ZT_LAST      = 4'd10;
    localparam logic [12:0] HALF_TURN   = 13'd5760;

    // ---------------------------------------------------------------- sine table
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] v;
        x  = (PI_HALF_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        s  = x;
        t  = x;
        for (int k = 1; k <= 19; k++)
        begin
            t = ((t * x2) >> 30) / 64'(TAYLOR_DIV[k]);
            if (k[0])
                s = s - t;
            else
                s = s + t;
        end
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32768)
            v = 64'd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [DIR_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + $signed(ACC_W'(16384));
        t = t >>> 15;
        if (t > $signed(ACC_W'(65535)))
            t = $signed(ACC_W'(65535));
        else if (t < -$signed(ACC_W'(65536)))
            t = -$signed(ACC_W'(65536));
        return t[DIR_W-1:0];
    endfunction

    logic [15:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    // ---------------------------------------------------------------- registers
    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [2:0] lk_sel_reg, lk_sel_next;
    logic [1:0] lk_phase_reg, lk_phase_next;

    logic [22:0] vision_range_reg;
    logic [22:0] reach_range_reg;
    logic [12:0] vision_angle_reg;
    logic [15:0] owner_id_reg;

    logic signed [COORD_WIDTH-1:0] vp_reg [3];
    logic signed [DIR_W-1:0]       dir_reg [3];

    logic [12:0] rot_reg [3];
    logic [15:0] id_reg;
    logic signed [OFF_W-1:0] off_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic signed [DIR_W-1:0] trig_reg [6];
    logic signed [DIR_W-1:0] c_reg;
    logic signed [DIR_W-1:0] crsp_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DIST_W-1:0] d_reg;
    logic [RSQ_W-1:0]  rng2_reg;
    logic [RSQ_W-1:0]  rch2_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [30:0] cm2_reg;
    logic [SQ_W-1:0] sqa_reg;
    logic [SQ_W-1:0] sqb_reg;
    logic res_vis_reg;
    logic res_rch_reg;
    logic [1:0] lk_q_reg;
    logic [N_W-1:0] lk_n_reg;
    logic [15:0] rom_q_reg;

    logic out_valid_reg;
    logic [15:0] out_id_reg;
    logic out_vis_reg;
    logic out_rch_reg;

    mul_op_t   mul_a;
    mul_op_t   mul_b;
    mul_prod_t mul_prod;

    vct_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // ---------------------------------------------------------------- config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_VISION_RANGE: prdata = 32'(vision_range_reg);
            REG_REACH_RANGE:  prdata = 32'(reach_range_reg);
            REG_VISION_ANGLE: prdata = 32'(vision_angle_reg);
            REG_OWNER_ID:     prdata = 32'(owner_id_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input offsets
    logic accept;
    logic owner_hit;
    logic near_c;
    logic signed [EXT_W-1:0] off_w [3];
    logic [EXT_W-1:0] mag_w [3];
    logic signed [COORD_WIDTH-1:0] pos_in [3];

    assign accept    = in_valid && !in_stall;
    assign owner_hit = (object_id == owner_id_reg);
    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    always_comb
    begin
        near_c = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            off_w[i] = EXT_W'(pos_in[i]) - EXT_W'(vp_reg[i]);
            mag_w[i] = off_w[i][EXT_W-1] ? EXT_W'(-off_w[i]) : EXT_W'(off_w[i]);
            if (mag_w[i] > (EXT_W'(1) << 23))
                near_c = 1'b0;
        end
    end

    // ---------------------------------------------------------------- sine lookup
    logic lk_cone;
    logic [QTR_W-1:0] quarter;
    logic [ANG_W-1:0] ang;
    logic [ANG_W-1:0] a_red;
    logic [ANG_W-1:0] q1, q2, q3, q4;
    logic [1:0] lk_q_c;
    logic [ANG_W-1:0] lk_r_c;
    logic [N_W-1:0] lk_n_c;
    logic [IDX_W-1:0] q0;
    logic [N_W:0] rem;
    logic [IDX_W:0] idx_w;
    logic [IDX_W-1:0] lk_idx_c;
    logic signed [DIR_W-1:0] lk_val;

    assign lk_cone = (lk_sel_reg == LK_CONE);
    assign quarter = lk_cone ? QUARTER_CONE : QUARTER_POSE;
    assign q1 = ANG_W'(quarter);
    assign q2 = q1 << 1;
    assign q3 = q1 + q2;
    assign q4 = q1 << 2;

    always_comb
    begin
        case (lk_sel_reg)
            3'd0:    ang = ANG_W'(rot_reg[0]);
            3'd1:    ang = ANG_W'(rot_reg[0]) + ANG_W'(QUARTER_POSE);
            3'd2:    ang = ANG_W'(rot_reg[1]);
            3'd3:    ang = ANG_W'(rot_reg[1]) + ANG_W'(QUARTER_POSE);
            3'd4:    ang = ANG_W'(rot_reg[2]);
            3'd5:    ang = ANG_W'(rot_reg[2]) + ANG_W'(QUARTER_POSE);
            3'd6:    ang = ANG_W'(vision_angle_reg) + ANG_W'(QUARTER_CONE);
            default: ang = '0;
        endcase
        a_red = (ang >= q4) ? ang - q4 : ang;
        if (a_red >= q3)
        begin
            lk_q_c = 2'd3;
            lk_r_c = a_red - q3;
        end
        else if (a_red >= q2)
        begin
            lk_q_c = 2'd2;
            lk_r_c = a_red - q2;
        end
        else if (a_red >= q1)
        begin
            lk_q_c = 2'd1;
            lk_r_c = a_red - q1;
        end
        else
        begin
            lk_q_c = 2'd0;
            lk_r_c = a_red;
        end
        // Odd quadrants run the quarter wave backward.
        if (lk_q_c[0])
            lk_r_c = q1 - lk_r_c;
        lk_n_c = N_W'(lk_r_c) * N_W'(SINE_TABLE_DEPTH) + N_W'(quarter >> 1);
    end

    // The reciprocal product undershoots the quotient by at most one.
    always_comb
    begin
        q0  = mul_prod[RECIP_SH +: IDX_W];
        rem = (N_W+1)'(lk_n_reg) - (N_W+1)'(q0) * (N_W+1)'(quarter);
        idx_w = (rem >= (N_W+1)'(quarter)) ? (IDX_W+1)'(q0) + 1'b1 : (IDX_W+1)'(q0);
        if (idx_w > (IDX_W+1)'(SINE_TABLE_DEPTH))
            idx_w = (IDX_W+1)'(SINE_TABLE_DEPTH);
        lk_idx_c = idx_w[IDX_W-1:0];
        lk_val = lk_q_reg[1] ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= sine_rom[lk_idx_c];
    end

    // ---------------------------------------------------------------- cone compare terms
    logic [Z_W-1:0] zm;
    logic [DIR_W-1:0] cm;
    logic [RSQ_W-1:0] rch2_now;
    logic wide_cone;
    logic range_ok;
    logic cone_vis;
    logic out_free;

    assign zm        = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);
    assign cm        = c_reg[DIR_W-1] ? DIR_W'(-c_reg) : DIR_W'(c_reg);
    assign rch2_now  = mul_prod[RSQ_W-1:0];
    assign wide_cone = vision_angle_reg > HALF_TURN;
    assign range_ok  = (d_reg != '0) && (d_reg < DIST_W'(rng2_reg));
    assign cone_vis  = c_reg[DIR_W-1] ? ((z_reg >= 0) || (sqa_reg < sqb_reg))
                                      : ((z_reg > 0) && (sqa_reg > sqb_reg));
    assign out_free  = !out_valid_reg || !out_stall;

    // ---------------------------------------------------------------- multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LK:
            begin
                mul_a = MUL_W'(lk_n_reg);
                mul_b = lk_cone ? MUL_W'(RECIP_CONE) : MUL_W'(RECIP_POSE);
            end
            ST_POSE:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = MUL_W'(trig_reg[1]); mul_b = MUL_W'(trig_reg[2]); end
                    4'd1:    begin mul_a = MUL_W'(trig_reg[1]); mul_b = MUL_W'(trig_reg[3]); end
                    4'd2:    begin mul_a = MUL_W'(crsp_reg);    mul_b = MUL_W'(trig_reg[5]); end
                    4'd3:    begin mul_a = MUL_W'(trig_reg[0]); mul_b = MUL_W'(trig_reg[4]); end
                    4'd4:    begin mul_a = MUL_W'(crsp_reg);    mul_b = MUL_W'(trig_reg[4]); end
                    4'd5:    begin mul_a = MUL_W'(trig_reg[0]); mul_b = MUL_W'(trig_reg[5]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_DIST:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = MUL_W'(mag_reg[0]); mul_b = MUL_W'(mag_reg[0]); end
                    4'd1:    begin mul_a = MUL_W'(mag_reg[1]); mul_b = MUL_W'(mag_reg[1]); end
                    4'd2:    begin mul_a = MUL_W'(mag_reg[2]); mul_b = MUL_W'(mag_reg[2]); end
                    4'd3:
                    begin
                        mul_a = MUL_W'(vision_range_reg);
                        mul_b = MUL_W'(vision_range_reg);
                    end
                    4'd4:
                    begin
                        mul_a = MUL_W'(reach_range_reg);
                        mul_b = MUL_W'(reach_range_reg);
                    end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_ZT:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = MUL_W'(dir_reg[0]); mul_b = MUL_W'(off_reg[0]); end
                    4'd1:    begin mul_a = MUL_W'(dir_reg[1]); mul_b = MUL_W'(off_reg[1]); end
                    4'd2:    begin mul_a = MUL_W'(dir_reg[2]); mul_b = MUL_W'(off_reg[2]); end
                    4'd3:    begin mul_a = MUL_W'(cm);         mul_b = MUL_W'(cm); end
                    4'd4:    begin mul_a = MUL_W'(zm[41:22]);  mul_b = MUL_W'(zm[41:22]); end
                    4'd5:    begin mul_a = MUL_W'(zm[41:22]);  mul_b = MUL_W'(zm[21:0]); end
                    4'd6:    begin mul_a = MUL_W'(zm[21:0]);   mul_b = MUL_W'(zm[21:0]); end
                    4'd7:    begin mul_a = MUL_W'(cm2_reg);    mul_b = MUL_W'(d_reg[47:24]); end
                    4'd8:    begin mul_a = MUL_W'(cm2_reg);    mul_b = MUL_W'(d_reg[23:0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        lk_sel_next   = lk_sel_reg;
        lk_phase_next = lk_phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_POSE)
                    begin
                        state_next    = ST_LK;
                        lk_sel_next   = '0;
                        lk_phase_next = '0;
                    end
                    else if (owner_hit || !near_c)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_DIST;
                        step_next  = '0;
                    end
                end
            end
            ST_LK:
            begin
                lk_phase_next = lk_phase_reg + 2'd1;
                if (lk_phase_reg == LK_LAST)
                begin
                    if (lk_sel_reg == LK_CONE)
                    begin
                        state_next = ST_ZT;
                        step_next  = '0;
                    end
                    else if (lk_sel_reg == LK_LAST_POSE)
                    begin
                        state_next = ST_POSE;
                        step_next  = '0;
                    end
                    else
                        lk_sel_next = lk_sel_reg + 3'd1;
                end
            end
            ST_POSE:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == POSE_LAST)
                    state_next = ST_IDLE;
            end
            ST_DIST:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == DIST_LAST)
                begin
                    if (!range_ok || wide_cone)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next    = ST_LK;
                        lk_sel_next   = LK_CONE;
                        lk_phase_next = '0;
                    end
                end
            end
            ST_ZT:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == ZT_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            lk_sel_reg       <= '0;
            lk_phase_reg     <= '0;
            vision_range_reg <= '0;
            reach_range_reg  <= '0;
            vision_angle_reg <= '0;
            owner_id_reg     <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vp_reg[i]  <= '0;
                dir_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            lk_sel_reg   <= lk_sel_next;
            lk_phase_reg <= lk_phase_next;

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_VISION_RANGE: vision_range_reg <= pwdata[22:0];
                    REG_REACH_RANGE:  reach_range_reg  <= pwdata[22:0];
                    REG_VISION_ANGLE: vision_angle_reg <= pwdata[12:0];
                    REG_OWNER_ID:     owner_id_reg     <= pwdata[15:0];
                    default:          owner_id_reg     <= owner_id_reg;
                endcase
            end

            if (accept && func == FUNC_POSE)
            begin
                vp_reg[0] <= pos_x;
                vp_reg[1] <= pos_y;
                vp_reg[2] <= pos_z;
            end

            if (state_reg == ST_POSE)
            begin
                case (step_reg)
                    4'd2:    dir_reg[2] <= round_q15(mul_prod[ACC_W-1:0]);
                    4'd4:    dir_reg[0] <= round_q15(acc_reg + $signed(mul_prod[ACC_W-1:0]));
                    4'd6:    dir_reg[1] <= round_q15(acc_reg - $signed(mul_prod[ACC_W-1:0]));
                    default: dir_reg[0] <= dir_reg[0];
                endcase
            end

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rot_reg[0]  <= rot_x;
            rot_reg[1]  <= rot_y;
            rot_reg[2]  <= rot_z;
            id_reg      <= object_id;
            res_vis_reg <= 1'b0;
            res_rch_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= off_w[i][OFF_W-1:0];
                mag_reg[i] <= mag_w[i][MAG_W-1:0];
            end
        end

        if (state_reg == ST_LK)
        begin
            case (lk_phase_reg)
                2'd0:
                begin
                    lk_q_reg <= lk_q_c;
                    lk_n_reg <= lk_n_c;
                end
                2'd3:
                begin
                    if (lk_cone)
                        c_reg <= lk_val;
                    else
                        trig_reg[lk_sel_reg] <= lk_val;
                end
                default: lk_q_reg <= lk_q_reg;
            endcase
        end

        if (state_reg == ST_POSE)
        begin
            case (step_reg)
                4'd1:    crsp_reg <= round_q15(mul_prod[ACC_W-1:0]);
                4'd3:    acc_reg  <= $signed(mul_prod[ACC_W-1:0]);
                4'd5:    acc_reg  <= $signed(mul_prod[ACC_W-1:0]);
                default: acc_reg  <= acc_reg;
            endcase
        end

        if (state_reg == ST_DIST)
        begin
            case (step_reg)
                4'd1: d_reg    <= mul_prod[DIST_W-1:0];
                4'd2: d_reg    <= d_reg + mul_prod[DIST_W-1:0];
                4'd3: d_reg    <= d_reg + mul_prod[DIST_W-1:0];
                4'd4: rng2_reg <= mul_prod[RSQ_W-1:0];
                4'd5:
                begin
                    rch2_reg    <= rch2_now;
                    res_vis_reg <= range_ok && wide_cone;
                    res_rch_reg <= range_ok && wide_cone && (reach_range_reg != '0)
                                   && (d_reg < DIST_W'(rch2_now));
                end
                default: d_reg <= d_reg;
            endcase
        end

        if (state_reg == ST_ZT)
        begin
            case (step_reg)
                4'd1:  z_reg   <= $signed(mul_prod[Z_W-1:0]);
                4'd2:  z_reg   <= z_reg + $signed(mul_prod[Z_W-1:0]);
                4'd3:  z_reg   <= z_reg + $signed(mul_prod[Z_W-1:0]);
                4'd4:  cm2_reg <= mul_prod[30:0];
                4'd5:  sqa_reg <= SQ_W'(mul_prod[47:0]) << 44;
                4'd6:  sqa_reg <= sqa_reg + (SQ_W'(mul_prod[47:0]) << 23);
                4'd7:  sqa_reg <= sqa_reg + SQ_W'(mul_prod[47:0]);
                4'd8:  sqb_reg <= SQ_W'(mul_prod[55:0]) << 24;
                4'd9:  sqb_reg <= sqb_reg + SQ_W'(mul_prod[55:0]);
                4'd10:
                begin
                    res_vis_reg <= cone_vis;
                    res_rch_reg <= cone_vis && (reach_range_reg != '0)
                                   && (d_reg < DIST_W'(rch2_reg));
                end
                default: z_reg <= z_reg;
            endcase
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_id_reg  <= id_reg;
            out_vis_reg <= res_vis_reg;
            out_rch_reg <= res_rch_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result_id = out_id_reg;
    assign visible   = out_vis_reg;
    assign reachable = out_rch_reg;

    // ---------------------------------------------------------------- assertions
    `VCT_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_reg != ST_IDLE,
        "accepted transfer did not start work")
    `VCT_ASSERT_IMPL(a_load_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE),
        "result appeared without a finished object test")
    `VCT_ASSERT_IMPL(a_reach_needs_vis, out_valid_reg, !out_rch_reg || out_vis_reg,
        "reachable result that is not visible")

endmodule
